@@ sv/assert_macros.svh @@
// Assertion macros shared by the row median filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge while reset is released.
`define RMF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check a property on every rising edge, reset included.
`define RMF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define RMF_ASSERT(label, clk, rst_n, prop)
`define RMF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ sv/rmf_pkg.sv @@
// Shared constants and window tap function for the row median filter.
`timescale 1ns / 1ps
`default_nettype none

package rmf_pkg;

  localparam int DATA_W      = 32;
  localparam int WINDOW_DEF  = 7;
  localparam int MAX_ROW_DEF = 2048;
  localparam int POS_W_DEF   = 11;
  // Wide enough for tap arithmetic at any window up to 15 taps.
  localparam int TAP_W       = 5;

  // History tap feeding window slot j. q is the newest position clipped at
  // twice the half window, k the distance from the newest position to the
  // window centre. Mirror about either row end, then clamp into the row.
  function automatic logic [TAP_W-1:0] win_tap(input logic [TAP_W-1:0] q,
                                               input logic [TAP_W-1:0] k,
                                               input logic [TAP_W-1:0] j,
                                               input logic [TAP_W-1:0] half,
                                               input logic [TAP_W-1:0] wlast);
    logic signed [TAP_W+2:0] qs;
    logic signed [TAP_W+2:0] idx;
    logic signed [TAP_W+2:0] d;
    qs  = signed'({3'b000, q});
    idx = qs - signed'({3'b000, k}) + signed'({3'b000, j}) - signed'({3'b000, half});
    if (idx < 0) idx = -idx;
    if (idx > qs) idx = (qs <<< 1) - idx;
    if (idx < 0) idx = '0;
    if (idx > qs) idx = qs;
    d = qs - idx;
    if (d > signed'({3'b000, wlast})) d = signed'({3'b000, wlast});
    return d[TAP_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/rmf_if.sv @@
// Valid/ready stream interfaces for the sample and median channels.
`timescale 1ns / 1ps
`default_nettype none

interface rmf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmf_pkg::DATA_W-1:0] sample;
  logic                              row_end;

  modport source (output valid, output sample, output row_end, input ready);
  modport sink   (input valid, input sample, input row_end, output ready);
endinterface

interface rmf_out_if #(
  parameter int POS_W = rmf_pkg::POS_W_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [rmf_pkg::DATA_W-1:0] median_value;
  logic        [POS_W-1:0]           out_position;
  logic                              row_last;

  modport source (output valid, output median_value, output out_position,
                  output row_last, input ready);
  modport sink   (input valid, input median_value, input out_position,
                  input row_last, output ready);
endinterface

`default_nettype wire

@@ sv/row_median_filter_reflect.sv @@
// Top level of the streaming row median filter with mirrored row ends.
//
// Usage: samples of a row enter on in_ch, one per transfer, the last one
// of the row with row_end set. Each median leaves on out_ch with its row
// position (saturating at MAX_ROW-1) and row_last on the final median of
// the row. The window is WINDOW taps centred on the position; taps past
// either row end are mirrored about the end sample.
// Throughput: one sample per cycle unless a stall or row end flush holds
// the issue stage. A sample at position WINDOW/2 or later yields one
// median. A row_end sample yields min(position, WINDOW/2) + 1 medians,
// one per cycle unless out_ch stalls, from the single issue stage that
// reads the history chain; in_ch.ready stays low until the last of them
// has been issued. A median is registered in the issue, window gather,
// rank and output stages after the transfer of the sample that makes it.
// Reset (rst_n low at a clock edge) empties the pipeline and returns the
// row position to zero; no clearing pass is needed.
// Stall: the output register holds its result while out_ch.ready is low;
// the earlier stages keep filling until the pipeline is full.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module row_median_filter_reflect #(
  parameter int WINDOW  = rmf_pkg::WINDOW_DEF,
  parameter int MAX_ROW = rmf_pkg::MAX_ROW_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rmf_in_if.sink    in_ch,
  rmf_out_if.source out_ch
);

  localparam int DW    = rmf_pkg::DATA_W;
  localparam int TW    = rmf_pkg::TAP_W;
  localparam int H     = WINDOW / 2;
  localparam int PMAX  = MAX_ROW - 1 + WINDOW;
  localparam int PCW   = $clog2(PMAX + 1);
  localparam int QW    = $clog2(2 * H + 1);
  localparam int KW    = $clog2(H + 1);
  localparam int IW    = $clog2(WINDOW);
  localparam int POS_W = $clog2(MAX_ROW);

  // ---------------------------------------------------------------- input
  logic in_xfer;
  logic p_ge_h;
  logic g_load;

  logic [PCW-1:0] pos_cnt_r, pos_cnt_nxt;

  // Issue stage
  logic           v_g_r, v_g_nxt;
  logic [KW-1:0]  k_g_r, k_g_nxt;
  logic [QW-1:0]  q_g_r, q_g_nxt;
  logic [PCW-1:0] p_g_r, p_g_nxt;
  logic           end_g_r, end_g_nxt;
  logic           g_fin, g_issue, g_done, g_free;

  // Gather, rank and output stages
  logic v_a_r, v_a_nxt, a_free, a_move;
  logic v_b_r, v_b_nxt, b_free, b_move;
  logic v_o_r, v_o_nxt, o_free;

  logic signed [DW-1:0] hist [WINDOW];
  logic [IW-1:0]        tap_sel [WINDOW];
  logic [PCW-1:0]       a_g;
  logic [POS_W-1:0]     pos_g;

  logic signed [DW-1:0] win_a_r [WINDOW];
  logic [POS_W-1:0]     pos_a_r;
  logic                 last_a_r;

  logic signed [DW-1:0] win_b_r [WINDOW];
  logic [WINDOW-1:0]    sel_b_r;
  logic [POS_W-1:0]     pos_b_r;
  logic                 last_b_r;
  logic signed [DW-1:0] med_b;

  logic signed [DW-1:0] med_o_r;
  logic [POS_W-1:0]     pos_o_r;
  logic                 last_o_r;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign p_ge_h  = (pos_cnt_r >= PCW'(H));
  assign g_load  = in_ch.row_end || p_ge_h;

  // --------------------------------------------------------- flow control
  assign o_free  = !v_o_r || out_ch.ready;
  assign b_free  = !v_b_r || o_free;
  assign b_move  = v_b_r && o_free;
  assign a_free  = !v_a_r || b_free;
  assign a_move  = v_a_r && b_free;
  assign g_fin   = !end_g_r || (k_g_r == '0);
  assign g_issue = v_g_r && a_free;
  assign g_done  = g_issue && g_fin;
  assign g_free  = !v_g_r || g_done;

  // Hold the history still until the issue stage has read its last window.
  assign in_ch.ready = g_free;

  // ------------------------------------------------------- history chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_tap
    if (i == 0) begin : g_head
      rmf_tap_cell u_cell (
        .clk      (clk),
        .shift_en (in_xfer),
        .d_in     (in_ch.sample),
        .value_r  (hist[i])
      );
    end else begin : g_body
      rmf_tap_cell u_cell (
        .clk      (clk),
        .shift_en (in_xfer),
        .d_in     (hist[i-1]),
        .value_r  (hist[i])
      );
    end
  end

  // ------------------------------------------------- position and issue
  always_comb begin
    pos_cnt_nxt = pos_cnt_r;
    v_g_nxt     = v_g_r;
    k_g_nxt     = k_g_r;
    q_g_nxt     = q_g_r;
    p_g_nxt     = p_g_r;
    end_g_nxt   = end_g_r;
    if (in_xfer) begin
      if (in_ch.row_end) begin
        pos_cnt_nxt = '0;
      end else if (pos_cnt_r != PCW'(PMAX)) begin
        pos_cnt_nxt = pos_cnt_r + PCW'(1);
      end
      v_g_nxt   = g_load;
      k_g_nxt   = p_ge_h || !in_ch.row_end ? KW'(H) : pos_cnt_r[KW-1:0];
      q_g_nxt   = (pos_cnt_r >= PCW'(2 * H)) ? QW'(2 * H) : pos_cnt_r[QW-1:0];
      p_g_nxt   = pos_cnt_r;
      end_g_nxt = in_ch.row_end;
    end else if (g_done) begin
      v_g_nxt = 1'b0;
    end else if (g_issue) begin
      k_g_nxt = k_g_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r <= '0;
      v_g_r     <= 1'b0;
    end else begin
      pos_cnt_r <= pos_cnt_nxt;
      v_g_r     <= v_g_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_g_r   <= k_g_nxt;
    q_g_r   <= q_g_nxt;
    p_g_r   <= p_g_nxt;
    end_g_r <= end_g_nxt;
  end

  // -------------------------------------------------------- window gather
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      tap_sel[j] = IW'(rmf_pkg::win_tap(TW'(q_g_r), TW'(k_g_r), TW'(j),
                                        TW'(H), TW'(WINDOW - 1)));
    end
    a_g   = p_g_r - PCW'(k_g_r);
    pos_g = (a_g > PCW'(MAX_ROW - 1)) ? POS_W'(MAX_ROW - 1) : a_g[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (g_issue) begin
      for (int j = 0; j < WINDOW; j++) begin
        win_a_r[j] <= hist[tap_sel[j]];
      end
      pos_a_r  <= pos_g;
      last_a_r <= end_g_r && (k_g_r == '0);
    end
  end

  // ----------------------------------------------------------- rank cells
  for (genvar j = 0; j < WINDOW; j++) begin : g_rank
    rmf_rank_cell #(
      .WINDOW (WINDOW),
      .SLOT   (j)
    ) u_rank (
      .clk     (clk),
      .load_en (a_move),
      .win     (win_a_r),
      .sel_r   (sel_b_r[j])
    );
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      win_b_r  <= win_a_r;
      pos_b_r  <= pos_a_r;
      last_b_r <= last_a_r;
    end
  end

  // ------------------------------------------------------- output register
  always_comb begin
    med_b = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (sel_b_r[j]) begin
        med_b = med_b | win_b_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      med_o_r  <= med_b;
      pos_o_r  <= pos_b_r;
      last_o_r <= last_b_r;
    end
  end

  always_comb begin
    v_a_nxt = a_free ? v_g_r : v_a_r;
    v_b_nxt = b_free ? v_a_r : v_b_r;
    v_o_nxt = o_free ? v_b_r : v_o_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_b_nxt;
      v_o_r <= v_o_nxt;
    end
  end

  assign out_ch.valid        = v_o_r;
  assign out_ch.median_value = med_o_r;
  assign out_ch.out_position = pos_o_r;
  assign out_ch.row_last     = last_o_r;

  // ----------------------------------------------------------- assertions
  `RMF_ASSERT(a_row_end_restarts, clk, rst_n, (in_xfer && in_ch.row_end) |=> (pos_cnt_r == '0))
  `RMF_ASSERT(a_row_end_flushes, clk, rst_n, (in_xfer && in_ch.row_end) |=> (v_g_r && end_g_r))
  `RMF_ASSERT(a_issue_holds, clk, rst_n, (v_g_r && !g_issue) |=> (v_g_r && $stable(k_g_r)))
  `RMF_ASSERT(a_one_median, clk, rst_n, v_b_r |-> $onehot(sel_b_r))
  `RMF_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_ch.valid)

endmodule

`default_nettype wire

@@ sv/rmf_tap_cell.sv @@
// One history cell: holds a sample and passes it on at each shift.
`timescale 1ns / 1ps
`default_nettype none

module rmf_tap_cell (
  input  wire logic                              clk,
  input  wire logic                              shift_en,
  input  wire logic signed [rmf_pkg::DATA_W-1:0] d_in,
  output logic signed      [rmf_pkg::DATA_W-1:0] value_r
);

  logic signed [rmf_pkg::DATA_W-1:0] value_nxt;

  assign value_nxt = shift_en ? d_in : value_r;

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

@@ sv/rmf_rank_cell.sv @@
// One window slot: ranks its sample against the others and flags the median.
`timescale 1ns / 1ps
`default_nettype none

module rmf_rank_cell #(
  parameter int WINDOW = rmf_pkg::WINDOW_DEF,
  parameter int SLOT   = 0
) (
  input  wire logic                              clk,
  input  wire logic                              load_en,
  input  wire logic signed [rmf_pkg::DATA_W-1:0] win [WINDOW],
  output logic                                   sel_r
);

  localparam int RW   = $clog2(WINDOW);
  localparam int HALF = WINDOW / 2;

  logic [RW-1:0] below;
  logic          sel_nxt;

  // Equal samples are ordered by slot so exactly one slot holds each rank.
  always_comb begin
    below = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (i != SLOT) begin
        if ((win[i] < win[SLOT]) || ((i < SLOT) && (win[i] == win[SLOT]))) begin
          below = below + RW'(1);
        end
      end
    end
    sel_nxt = (below == RW'(HALF));
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      sel_r <= sel_nxt;
    end
  end

endmodule

`default_nettype wire
